### rtl/lusf_pkg.sv
`timescale 1ns / 1ps

package lusf_pkg;

    // Fixed widths of the fields and of the internal slope arithmetic.
    localparam int SAMPLE_W = 32;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int SUM_W    = 48;
    localparam int THETA_W  = 16;
    localparam int OPND_W   = 32;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int SLOPE_W  = 52;
    localparam int MAG_W    = 63;

    // Axis codes of an input word.
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_THETA = 2'd0;
    localparam logic [1:0] CFG_INV_X = 2'd1;
    localparam logic [1:0] CFG_INV_Y = 2'd2;
    localparam logic [1:0] CFG_INV_Z = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [THETA_W-1:0] THETA_RESET = 16'd16384;
    localparam logic [OPND_W-1:0]  INV_RESET   = 32'd65536;

    // Right shifts and rounding constants of the three scaling steps.
    localparam int SH_VEL = 30;
    localparam int SH_WGT = 28;
    localparam int SH_INV = 31;

    typedef logic signed [SLOPE_W-1:0] t_slope;

    typedef struct packed {
        logic [1:0]                 axis;
        logic signed [SAMPLE_W-1:0] sample_minus2;
        logic signed [SAMPLE_W-1:0] sample_minus1;
        logic signed [SAMPLE_W-1:0] sample_centre;
        logic signed [SAMPLE_W-1:0] sample_plus1;
        logic signed [SAMPLE_W-1:0] sample_plus2;
        logic signed [SAMPLE_W-1:0] velocity;
        logic [OPND_W-1:0]          weight;
    } t_in_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] flux_term;
        logic                    saturated;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_THETA0,
        ST_THETA1,
        ST_THETA2,
        ST_THSTORE,
        ST_INNER,
        ST_OUTER,
        ST_DIFF,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_FIN,
        ST_CLIP,
        ST_ACC
    } t_state;

    typedef enum logic [1:0] {
        STEP_VEL,
        STEP_WGT,
        STEP_INV
    } t_step;

    // Minmod with the sign of zero taken as positive.
    function automatic t_slope minmod(input t_slope a, input t_slope b);
        logic   pos;
        t_slope mag;
        t_slope bs;
        t_slope m;
        pos = ~a[SLOPE_W-1];
        mag = pos ? a : -a;
        bs  = pos ? b : -b;
        m   = (mag < bs) ? mag : bs;
        if (m < 0) begin
            m = '0;
        end
        return pos ? m : -m;
    endfunction

endpackage

### rtl/lusf_mul.sv
`timescale 1ns / 1ps

module lusf_mul
    import lusf_pkg::*;
(
    input  logic              i_clk,
    input  logic [OPND_W-1:0] i_a,
    input  logic [OPND_W-1:0] i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    // Registered unsigned 32 x 32 product, shared by every step of the sequencer.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### rtl/limited_upwind_flux_stencil.sv
`timescale 1ns / 1ps

// Limited upwind flux stencil for one cell, one axis word at a time.
// The input channel takes a word with the axis code, five samples along that
// axis, the velocity component and the quadrature weight. A word is taken when
// i_in_valid is high and o_in_stall is low; o_in_stall is high while a word is
// being worked on. A word with axis code three is taken and dropped.
// Each word is worked through a sequencer around one registered 32 x 32
// multiplier, used nine times: three theta products and two partial products
// for each of the velocity, weight and spacing scalings. A new word is not
// taken before the block is through with the last one. x and y words only
// add their term to the running sum; a z word adds its term and puts the
// saturated sum and its flag into the output register, then clears the sum.
// The output word is held while i_out_stall is high; a z word that finds the
// output register still full waits for it, with the input stalled. The
// configuration port writes one register per cycle and is meant for use while
// the block is idle. Synchronous reset loads the register defaults, clears the
// running sum and empties the output register.
module limited_upwind_flux_stencil
    import lusf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [OPND_W-1:0] i_cfg_data
);

    localparam logic [MAG_W-1:0] MAG_LIM     = MAG_W'(1) << 62;
    localparam logic [MAG_W-1:0] MAG_MAX_POS = (MAG_W'(1) << (SUM_W - 1)) - MAG_W'(1);
    localparam logic [MAG_W-1:0] MAG_MAX_NEG = MAG_W'(1) << (SUM_W - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam int ACC_W  = PROD_W + 1;
    localparam int WIDE_W = PROD_W + OPND_W;

    // Configuration registers.
    logic [THETA_W-1:0] r_theta;
    logic [OPND_W-1:0]  r_inv_x;
    logic [OPND_W-1:0]  r_inv_y;
    logic [OPND_W-1:0]  r_inv_z;

    // Sequencer.
    t_state r_state;
    t_state n_state;
    t_step  r_step;

    // Working registers of one word.
    logic signed [DIFF_W-1:0] r_dif [3];
    t_slope                   r_t [3];
    t_slope                   r_slope_a;
    t_slope                   r_slope_b;
    logic                     r_vel_pos;
    logic                     r_vel_neg;
    logic                     r_axis_z;
    logic [OPND_W-1:0]        r_vmag;
    logic [OPND_W-1:0]        r_weight;
    logic [OPND_W-1:0]        r_inv;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic [ACC_W-1:0]         r_acc;
    logic signed [SUM_W-1:0]  r_term;

    // Running state and output register.
    logic signed [SUM_W-1:0] r_axis_sum;
    logic                    r_sum_clipped;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    // Multiplier connection.
    logic [OPND_W-1:0] w_mul_a;
    logic [OPND_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_prod;

    logic w_in_take;
    logic w_out_free;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    lusf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= THETA_RESET;
            r_inv_x <= INV_RESET;
            r_inv_y <= INV_RESET;
            r_inv_z <= INV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THETA: r_theta <= i_cfg_data[THETA_W-1:0];
                CFG_INV_X: r_inv_x <= i_cfg_data;
                CFG_INV_Y: r_inv_y <= i_cfg_data;
                CFG_INV_Z: r_inv_z <= i_cfg_data;
                default:   r_theta <= r_theta;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and input stall.
    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_word.axis != AXIS_NONE) begin
                    n_state = ST_THETA0;
                end
            end
            ST_THETA0:  n_state = ST_THETA1;
            ST_THETA1:  n_state = ST_THETA2;
            ST_THETA2:  n_state = ST_THSTORE;
            ST_THSTORE: n_state = ST_INNER;
            ST_INNER:   n_state = ST_OUTER;
            ST_OUTER:   n_state = ST_DIFF;
            ST_DIFF:    n_state = ST_MUL_LO;
            ST_MUL_LO:  n_state = ST_MUL_HI;
            ST_MUL_HI:  n_state = ST_MUL_FIN;
            ST_MUL_FIN: n_state = (r_step == STEP_INV) ? ST_CLIP : ST_MUL_LO;
            ST_CLIP:    n_state = ST_ACC;
            ST_ACC: begin
                if (!r_axis_z || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Multiplier operands: difference magnitudes times theta, then the two
    // halves of the running magnitude times the scaling operand of the step.
    logic [OPND_W-1:0] w_step_opnd;
    logic [DIFF_W-1:0] w_dabs [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dabs[k] = r_dif[k][DIFF_W-1] ? DIFF_W'(-r_dif[k]) : DIFF_W'(r_dif[k]);
        end
        unique case (r_step)
            STEP_VEL: w_step_opnd = r_vmag;
            STEP_WGT: w_step_opnd = r_weight;
            STEP_INV: w_step_opnd = r_inv;
            default:  w_step_opnd = r_inv;
        endcase
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_THETA0: begin
                w_mul_a = w_dabs[0][OPND_W-1:0];
                w_mul_b = OPND_W'(r_theta);
            end
            ST_THETA1: begin
                w_mul_a = w_dabs[1][OPND_W-1:0];
                w_mul_b = OPND_W'(r_theta);
            end
            ST_THETA2: begin
                w_mul_a = w_dabs[2][OPND_W-1:0];
                w_mul_b = OPND_W'(r_theta);
            end
            ST_MUL_LO: begin
                w_mul_a = r_mag[OPND_W-1:0];
                w_mul_b = w_step_opnd;
            end
            ST_MUL_HI: begin
                w_mul_a = OPND_W'(r_mag[MAG_W-1:OPND_W]);
                w_mul_b = w_step_opnd;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Upwind window at the input: (a, b, c, e) is (m2, m1, c, p1) for positive
    // velocity and (m1, c, p1, p2) otherwise.
    logic                       w_pos;
    logic signed [SAMPLE_W-1:0] w_wa;
    logic signed [SAMPLE_W-1:0] w_wb;
    logic signed [SAMPLE_W-1:0] w_wc;
    logic signed [SAMPLE_W-1:0] w_we;
    logic [OPND_W-1:0]          w_inv_sel;

    always_comb begin
        w_pos = (i_in_word.velocity > 0);
        if (w_pos) begin
            w_wa = i_in_word.sample_minus2;
            w_wb = i_in_word.sample_minus1;
            w_wc = i_in_word.sample_centre;
            w_we = i_in_word.sample_plus1;
        end else begin
            w_wa = i_in_word.sample_minus1;
            w_wb = i_in_word.sample_centre;
            w_wc = i_in_word.sample_plus1;
            w_we = i_in_word.sample_plus2;
        end
        unique case (i_in_word.axis)
            AXIS_X:  w_inv_sel = r_inv_x;
            AXIS_Y:  w_inv_sel = r_inv_y;
            default: w_inv_sel = r_inv_z;
        endcase
    end

    // Theta product from the multiplier as a signed value; the difference sign is applied when it is stored.
    logic signed [SLOPE_W-1:0] w_prod_s;
    assign w_prod_s = $signed({1'b0, w_prod[SLOPE_W-2:0]});

    // Half slopes (sum of two adjacent differences * 2^13) and the centered flux difference.
    logic signed [DIFF_W:0] w_s01;
    logic signed [DIFF_W:0] w_s12;
    t_slope                 w_h01;
    t_slope                 w_h12;
    t_slope                 w_d;
    logic [SLOPE_W-1:0]     w_dmag;

    always_comb begin
        w_s01  = {r_dif[0][DIFF_W-1], r_dif[0]} + {r_dif[1][DIFF_W-1], r_dif[1]};
        w_s12  = {r_dif[1][DIFF_W-1], r_dif[1]} + {r_dif[2][DIFF_W-1], r_dif[2]};
        w_h01  = t_slope'(w_s01) <<< 13;
        w_h12  = t_slope'(w_s12) <<< 13;
        w_d    = (t_slope'(r_dif[1]) <<< 15) +
                 (r_vel_pos ? (r_slope_a - r_slope_b) : (r_slope_b - r_slope_a));
        w_dmag = (w_d < 0) ? SLOPE_W'(-w_d) : SLOPE_W'(w_d);
    end

    // Rounding and saturation of one scaling step.
    logic [ACC_W-1:0]  w_rnd;
    logic [WIDE_W-1:0] w_wide;
    logic [WIDE_W-1:0] w_res;
    logic              w_res_sat;

    always_comb begin
        w_wide = WIDE_W'(r_acc) + {w_prod, {OPND_W{1'b0}}};
        unique case (r_step)
            STEP_VEL: begin
                w_rnd = ACC_W'(1) << (SH_VEL - 1);
                w_res = w_wide >> SH_VEL;
            end
            STEP_WGT: begin
                w_rnd = ACC_W'(1) << (SH_WGT - 1);
                w_res = w_wide >> SH_WGT;
            end
            default: begin
                w_rnd = ACC_W'(1) << (SH_INV - 1);
                w_res = w_wide >> SH_INV;
            end
        endcase
        w_res_sat = (w_res > WIDE_W'(MAG_LIM));
    end

    // Term clipping and accumulation.
    logic                    w_term_clip;
    logic signed [SUM_W-1:0] w_term;
    logic signed [SUM_W:0]   w_acc_sum;
    logic                    w_acc_ovf;
    logic signed [SUM_W-1:0] w_acc_val;

    always_comb begin
        w_term_clip = 1'b0;
        if (r_neg) begin
            if (r_mag > MAG_MAX_NEG) begin
                w_term_clip = 1'b1;
                w_term      = SUM_MIN;
            end else begin
                w_term = -$signed(r_mag[SUM_W-1:0]);
            end
        end else begin
            if (r_mag > MAG_MAX_POS) begin
                w_term_clip = 1'b1;
                w_term      = SUM_MAX;
            end else begin
                w_term = $signed(r_mag[SUM_W-1:0]);
            end
        end
        w_acc_sum = {r_axis_sum[SUM_W-1], r_axis_sum} + {r_term[SUM_W-1], r_term};
        w_acc_ovf = (w_acc_sum[SUM_W] != w_acc_sum[SUM_W-1]);
        if (w_acc_ovf) begin
            w_acc_val = w_acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_acc_val = w_acc_sum[SUM_W-1:0];
        end
    end

    // Datapath registers of the word in work.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    r_dif[0]  <= {w_wb[SAMPLE_W-1], w_wb} - {w_wa[SAMPLE_W-1], w_wa};
                    r_dif[1]  <= {w_wc[SAMPLE_W-1], w_wc} - {w_wb[SAMPLE_W-1], w_wb};
                    r_dif[2]  <= {w_we[SAMPLE_W-1], w_we} - {w_wc[SAMPLE_W-1], w_wc};
                    r_vel_pos <= w_pos;
                    r_vel_neg <= i_in_word.velocity[SAMPLE_W-1];
                    r_vmag    <= i_in_word.velocity[SAMPLE_W-1] ?
                                 OPND_W'(-i_in_word.velocity) :
                                 OPND_W'(i_in_word.velocity);
                    r_weight  <= i_in_word.weight;
                    r_inv     <= w_inv_sel;
                    r_axis_z  <= (i_in_word.axis == AXIS_Z);
                end
            end
            ST_THETA1:  r_t[0] <= r_dif[0][DIFF_W-1] ? -w_prod_s : w_prod_s;
            ST_THETA2:  r_t[1] <= r_dif[1][DIFF_W-1] ? -w_prod_s : w_prod_s;
            ST_THSTORE: r_t[2] <= r_dif[2][DIFF_W-1] ? -w_prod_s : w_prod_s;
            ST_INNER: begin
                r_slope_a <= minmod(w_h12, r_t[1]);
                r_slope_b <= minmod(w_h01, r_t[0]);
            end
            ST_OUTER: begin
                r_slope_a <= minmod(r_t[2], r_slope_a);
                r_slope_b <= minmod(r_t[1], r_slope_b);
            end
            ST_DIFF: begin
                r_neg  <= (w_d < 0) != r_vel_neg;
                r_mag  <= MAG_W'(w_dmag);
                r_step <= STEP_VEL;
            end
            ST_MUL_HI:  r_acc <= {1'b0, w_prod} + w_rnd;
            ST_MUL_FIN: begin
                r_mag <= w_res_sat ? MAG_LIM : w_res[MAG_W-1:0];
                unique case (r_step)
                    STEP_VEL: r_step <= STEP_WGT;
                    default:  r_step <= STEP_INV;
                endcase
            end
            ST_CLIP:    r_term <= w_term;
            default:    r_term <= r_term;
        endcase
    end

    // Running sum, clip flag and output register. A z word that loads the
    // output register takes priority over the drain of the previous word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_sum    <= '0;
            r_sum_clipped <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_state == ST_CLIP && w_term_clip) begin
                r_sum_clipped <= 1'b1;
            end
            if (r_state == ST_ACC && r_axis_z && w_out_free) begin
                r_out_valid   <= 1'b1;
                r_axis_sum    <= '0;
                r_sum_clipped <= 1'b0;
            end else begin
                if (r_out_valid && !i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
                if (r_state == ST_ACC && !r_axis_z) begin
                    r_axis_sum    <= w_acc_val;
                    r_sum_clipped <= r_sum_clipped | w_acc_ovf;
                end
            end
        end
    end

    // Output word payload, loaded when a z word finishes.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ACC && r_axis_z && w_out_free) begin
            r_out_word.flux_term <= w_acc_val;
            r_out_word.saturated <= r_sum_clipped | w_acc_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
